// ===== sv/gtsa_pkg.sv =====
package gtsa_pkg;

    localparam int SLOT_COUNT      = 64;
    localparam int PAYLOAD_BITS    = 64;
    localparam int GENERATION_BITS = 32;

    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int OP_W    = 3;
    localparam int INDEX_W = 8;
    localparam int DATA_W  = 64;
    localparam int EXPECT_W = 32;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 6;
    localparam int GEN_OUT_W = 32;
    localparam int ACTIVE_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE        = 3'd0,
        OP_RELEASE        = 3'd1,
        OP_SILENT_RELEASE = 3'd2,
        OP_LOOKUP         = 3'd3,
        OP_VALIDATE       = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_NO_FREE     = 2'd1,
        ST_OUT_OF_RANGE = 2'd2,
        ST_NOT_OCCUPIED = 2'd3
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } find_t;

endpackage

// ===== sv/gtsa_if.sv =====
interface gtsa_req_if;
    import gtsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [INDEX_W-1:0]  slot_index;
    logic [DATA_W-1:0]   store_data;
    logic [EXPECT_W-1:0] check_gen;

    modport source (output valid, output op, output slot_index, output store_data,
                    output check_gen, input ready);
    modport sink (input valid, input op, input slot_index, input store_data,
                  input check_gen, output ready);
endinterface

interface gtsa_rsp_if;
    import gtsa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [GRANT_W-1:0]   granted_slot;
    logic [DATA_W-1:0]    read_data;
    logic [GEN_OUT_W-1:0] generation_out;
    logic                 is_occupied;
    logic                 is_valid;
    logic                 evict;
    logic [ACTIVE_W-1:0]  active_slots;

    modport source (output valid, output status, output granted_slot, output read_data,
                    output generation_out, output is_occupied, output is_valid,
                    output evict, output active_slots, input ready);
    modport sink (input valid, input status, input granted_slot, input read_data,
                  input generation_out, input is_occupied, input is_valid,
                  input evict, input active_slots, output ready);
endinterface

// ===== sv/generation_tagged_slot_allocator_top.sv =====
// Generational slot allocator: each request word is handled in an accept step and then an
// execute step, which waits while the previous result still waits unaccepted in the output
// register. On accept the request word is registered, a rotating priority encoder over the
// occupancy register picks the free slot for an acquire, and the payload and generation
// memories are read at the chosen slot; on execute the result is formed, the memories are
// written for a granted acquire and the result is loaded into the output register. A finished
// result may wait in that register while the next request word is accepted. There is no clearing pass
// after reset: generations that were never written read as zero by way of one valid bit
// per slot.
module generation_tagged_slot_allocator_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    gtsa_req_if.sink        req,
    gtsa_rsp_if.source      rsp
);
    import gtsa_pkg::*;

    fsm_t                       st_reg;
    fsm_t                       st_next;
    logic                       evict_notify_reg;
    logic [SLOT_COUNT-1:0]      occ_reg;
    logic [SLOT_COUNT-1:0]      occ_next;
    logic [SLOT_COUNT-1:0]      gen_vld_reg;
    logic [SLOT_W-1:0]          hint_reg;
    logic [SLOT_W-1:0]          hint_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;

    op_t                        op_reg;
    logic                       in_range_reg;
    logic                       occ_at_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic                       found_reg;
    logic [PAYLOAD_BITS-1:0]    data_reg;
    logic [EXPECT_W-1:0]        expect_reg;

    logic                       rsp_valid_reg;
    status_t                    status_reg;
    status_t                    status_next;
    logic [GRANT_W-1:0]         grant_reg;
    logic [GRANT_W-1:0]         grant_next;
    logic [DATA_W-1:0]          rdata_reg;
    logic [DATA_W-1:0]          rdata_next;
    logic [GEN_OUT_W-1:0]       gen_out_reg;
    logic [GEN_OUT_W-1:0]       gen_out_next;
    logic                       occ_out_reg;
    logic                       occ_out_next;
    logic                       valid_out_reg;
    logic                       valid_out_next;
    logic                       evict_reg;
    logic                       evict_next;
    logic [ACTIVE_W-1:0]        active_reg;

    find_t                      find;
    logic                       accept;
    logic                       commit;
    logic                       acq_write;
    logic                       in_range;
    logic [SLOT_W-1:0]          rd_addr;
    logic [PAYLOAD_BITS-1:0]    pl_rdata;
    logic [GENERATION_BITS-1:0] gen_rdata;
    logic [GENERATION_BITS-1:0] gen_cur;
    logic [GENERATION_BITS-1:0] gen_inc;

    gtsa_finder u_finder (
        .occ  (occ_reg),
        .hint (hint_reg),
        .find (find)
    );

    assign in_range = (9'(req.slot_index) < 9'(SLOT_COUNT));
    assign rd_addr  = (op_t'(req.op) == OP_ACQUIRE) ? find.slot
                                                     : req.slot_index[SLOT_W-1:0];
    assign accept   = req.valid && req.ready;

    gtsa_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_payload_ram (
        .clk   (clk),
        .we    (acq_write),
        .waddr (slot_reg),
        .wdata (data_reg),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (pl_rdata)
    );

    gtsa_ram #(
        .WIDTH (GENERATION_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_generation_ram (
        .clk   (clk),
        .we    (acq_write),
        .waddr (slot_reg),
        .wdata (gen_inc),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (gen_rdata)
    );

    assign gen_cur = gen_vld_reg[slot_reg] ? gen_rdata : '0;
    assign gen_inc = gen_cur + 1'b1;

    always_comb
    begin
        st_next   = st_reg;
        req.ready = 1'b0;
        commit    = 1'b0;
        unique case (st_reg)
            FSM_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    st_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    commit  = 1'b1;
                    st_next = FSM_IDLE;
                end
            end
            default:
            begin
                st_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        occ_next       = occ_reg;
        hint_next      = hint_reg;
        cnt_next       = cnt_reg;
        acq_write      = 1'b0;
        status_next    = ST_OK;
        grant_next     = '0;
        rdata_next     = '0;
        gen_out_next   = '0;
        occ_out_next   = 1'b0;
        valid_out_next = 1'b0;
        evict_next     = 1'b0;
        case (op_reg) inside
            OP_ACQUIRE:
            begin
                if (found_reg)
                begin
                    acq_write          = commit;
                    occ_next[slot_reg] = 1'b1;
                    hint_next          = (slot_reg == SLOT_W'(SLOT_COUNT - 1))
                                         ? '0 : slot_reg + 1'b1;
                    cnt_next           = cnt_reg + 1'b1;
                    grant_next         = GRANT_W'(slot_reg);
                    gen_out_next       = GEN_OUT_W'(gen_inc);
                end
                else
                begin
                    status_next = ST_NO_FREE;
                end
            end
            OP_RELEASE, OP_SILENT_RELEASE, OP_LOOKUP, OP_VALIDATE:
            begin
                if (!in_range_reg)
                begin
                    status_next = ST_OUT_OF_RANGE;
                end
                else
                begin
                    occ_out_next = occ_at_reg;
                    gen_out_next = GEN_OUT_W'(gen_cur);
                    if (!occ_at_reg)
                    begin
                        status_next = ST_NOT_OCCUPIED;
                    end
                    else if (op_reg == OP_VALIDATE)
                    begin
                        valid_out_next = (expect_reg == '0)
                                         || (64'(gen_cur) == 64'(expect_reg));
                    end
                    else
                    begin
                        rdata_next = DATA_W'(pl_rdata);
                        if (op_reg != OP_LOOKUP)
                        begin
                            evict_next = (op_reg == OP_RELEASE) && evict_notify_reg
                                         && (pl_rdata != '0);
                            occ_next[slot_reg] = 1'b0;
                            if (cnt_reg != '0)
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg           <= FSM_IDLE;
            evict_notify_reg <= 1'b0;
            occ_reg          <= '0;
            gen_vld_reg      <= '0;
            hint_reg         <= '0;
            cnt_reg          <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
            begin
                evict_notify_reg <= cfg_wdata;
            end
            if (commit)
            begin
                occ_reg       <= occ_next;
                hint_reg      <= hint_next;
                cnt_reg       <= cnt_next;
                rsp_valid_reg <= 1'b1;
                if (acq_write)
                begin
                    gen_vld_reg[slot_reg] <= 1'b1;
                end
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op_t'(req.op);
            in_range_reg <= in_range;
            occ_at_reg   <= in_range && occ_reg[rd_addr];
            slot_reg     <= rd_addr;
            found_reg    <= find.found;
            data_reg     <= PAYLOAD_BITS'(req.store_data);
            expect_reg   <= req.check_gen;
        end
        if (commit)
        begin
            status_reg    <= status_next;
            grant_reg     <= grant_next;
            rdata_reg     <= rdata_next;
            gen_out_reg   <= gen_out_next;
            occ_out_reg   <= occ_out_next;
            valid_out_reg <= valid_out_next;
            evict_reg     <= evict_next;
            active_reg    <= ACTIVE_W'(cnt_next);
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.granted_slot   = grant_reg;
    assign rsp.read_data      = rdata_reg;
    assign rsp.generation_out = gen_out_reg;
    assign rsp.is_occupied    = occ_out_reg;
    assign rsp.is_valid       = valid_out_reg;
    assign rsp.evict          = evict_reg;
    assign rsp.active_slots   = active_reg;

`ifndef NO_ASSERTIONS
    // The active count always equals the number of occupied slots.
    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_reg) == int'(cnt_reg))
        else $error("active count differs from occupancy map");

    // An acquire only ever grants a slot that was free.
    a_grant_is_free: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && op_reg == OP_ACQUIRE && found_reg) |-> !occ_reg[slot_reg])
        else $error("acquire granted an occupied slot");

    // A granted slot is marked occupied once the acquire completes.
    a_grant_marks_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && op_reg == OP_ACQUIRE && found_reg) |=> occ_reg[$past(slot_reg)])
        else $error("granted slot not marked occupied");

    // An acquire reports a full table only when every slot is occupied.
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op_t'(req.op) == OP_ACQUIRE && !find.found) |-> (&occ_reg))
        else $error("table reported full with a free slot");
`endif
endmodule

// ===== sv/gtsa_ram.sv =====
module gtsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/gtsa_finder.sv =====
module gtsa_finder (
    input  logic [gtsa_pkg::SLOT_COUNT-1:0] occ,
    input  logic [gtsa_pkg::SLOT_W-1:0]     hint,
    output gtsa_pkg::find_t                 find
);
    import gtsa_pkg::*;

    logic [SLOT_COUNT-1:0] free_map;
    logic [SLOT_COUNT-1:0] upper_map;
    logic [SLOT_W-1:0]     upper_slot;
    logic [SLOT_W-1:0]     any_slot;

    // The first free slot at or above the hint wins; otherwise the search wraps to slot zero.
    always_comb
    begin
        free_map   = ~occ;
        upper_slot = '0;
        any_slot   = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            upper_map[i] = free_map[i] && (SLOT_W'(i) >= hint);
        end
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (upper_map[i])
            begin
                upper_slot = SLOT_W'(i);
            end
            if (free_map[i])
            begin
                any_slot = SLOT_W'(i);
            end
        end
        find.found = |free_map;
        find.slot  = (|upper_map) ? upper_slot : any_slot;
    end
endmodule

// ===== tb/generation_tagged_slot_allocator_top_tb.sv =====
`timescale 1ns / 1ps

module generation_tagged_slot_allocator_top_tb;
    import gtsa_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
    localparam int MAX_IDLE      = 14;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        status_t              status;
        logic [GRANT_W-1:0]   granted_slot;
        logic [DATA_W-1:0]    read_data;
        logic [GEN_OUT_W-1:0] generation_out;
        logic                 is_occupied;
        logic                 is_valid;
        logic                 evict;
        logic [ACTIVE_W-1:0]  active_slots;
    } alloc_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    gtsa_req_if req ();
    gtsa_rsp_if rsp ();

    generation_tagged_slot_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    bit                         slot_busy [SLOT_COUNT];
    logic [PAYLOAD_BITS-1:0]    slot_word [SLOT_COUNT];
    logic [GENERATION_BITS-1:0] slot_gen  [SLOT_COUNT];
    int unsigned                next_hint;
    int unsigned                busy_count;
    bit                         notify_on;

    alloc_result_t awaited_responses [$];

    bit sender_idle;
    bit sink_idle;
    int mismatch_count;
    int words_sent;
    int results_checked;
    int no_free_seen;
    int out_of_range_seen;
    int evictions_seen;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic alloc_result_t allocator_response(logic [OP_W-1:0] op,
                                                        logic [INDEX_W-1:0] idx,
                                                        logic [DATA_W-1:0] data,
                                                        logic [EXPECT_W-1:0] want_gen);
        alloc_result_t r;
        int unsigned   s;
        int unsigned   step;
        bit            found;
        r = '0;
        found = 1'b0;
        if (op == OP_ACQUIRE)
        begin
            for (step = 0; step < SLOT_COUNT && !found; step++)
            begin
                s = (next_hint + step) % SLOT_COUNT;
                if (!slot_busy[s])
                begin
                    found = 1'b1;
                    slot_busy[s] = 1'b1;
                    slot_word[s] = data;
                    slot_gen[s] = slot_gen[s] + 1'b1;
                    next_hint = (s + 1) % SLOT_COUNT;
                    busy_count++;
                    r.granted_slot = GRANT_W'(s);
                    r.generation_out = GEN_OUT_W'(slot_gen[s]);
                end
            end
            if (found)
                r.status = ST_OK;
            else
                r.status = ST_NO_FREE;
        end
        else if (op >= OP_RELEASE && op <= OP_VALIDATE)
        begin
            if (idx >= SLOT_COUNT)
            begin
                r.status = ST_OUT_OF_RANGE;
            end
            else
            begin
                s = 32'(idx);
                r.is_occupied = slot_busy[s];
                r.generation_out = GEN_OUT_W'(slot_gen[s]);
                if (!slot_busy[s])
                begin
                    r.status = ST_NOT_OCCUPIED;
                end
                else if (op == OP_RELEASE || op == OP_SILENT_RELEASE)
                begin
                    r.read_data = slot_word[s];
                    r.evict = (op == OP_RELEASE) && notify_on && (slot_word[s] != '0);
                    slot_word[s] = '0;
                    slot_busy[s] = 1'b0;
                    if (busy_count > 0)
                        busy_count--;
                end
                else if (op == OP_LOOKUP)
                begin
                    r.read_data = slot_word[s];
                end
                else
                begin
                    r.is_valid = (want_gen == '0) || (slot_gen[s] == want_gen);
                end
            end
        end
        r.active_slots = ACTIVE_W'(busy_count);
        return r;
    endfunction

    task automatic send_word(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                             logic [DATA_W-1:0] data, logic [EXPECT_W-1:0] want_gen);
        int            gap;
        alloc_result_t predicted;
        gap = sender_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op <= op;
        req.slot_index <= idx;
        req.store_data <= data;
        req.check_gen <= want_gen;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        predicted = allocator_response(op, idx, data, want_gen);
        awaited_responses.push_back(predicted);
        words_sent++;
        if (predicted.status == ST_NO_FREE)
            no_free_seen++;
        if (predicted.status == ST_OUT_OF_RANGE)
            out_of_range_seen++;
        if (predicted.evict)
            evictions_seen++;
    endtask

    task automatic settle();
        req.valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_notify(bit value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        notify_on = value;
    endtask

    function automatic logic [INDEX_W-1:0] pick_busy_slot();
        int unsigned start;
        int unsigned k;
        start = $urandom_range(0, SLOT_COUNT - 1);
        for (k = 0; k < SLOT_COUNT; k++)
        begin
            if (slot_busy[(start + k) % SLOT_COUNT])
                return INDEX_W'((start + k) % SLOT_COUNT);
        end
        return INDEX_W'(start);
    endfunction

    function automatic logic [DATA_W-1:0] random_data();
        logic [DATA_W-1:0] data;
        data = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: data = '0;
            1: data = '1;
            default: ;
        endcase
        return data;
    endfunction

    task automatic random_word(int acquire_pct);
        logic [OP_W-1:0]     op;
        logic [INDEX_W-1:0]  idx;
        logic [EXPECT_W-1:0] want_gen;
        int                  roll;
        roll = $urandom_range(0, 99);
        if (roll < acquire_pct)
            op = OP_ACQUIRE;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            else if (roll < 35)
                op = OP_RELEASE;
            else if (roll < 50)
                op = OP_SILENT_RELEASE;
            else if (roll < 75)
                op = OP_LOOKUP;
            else
                op = OP_VALIDATE;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60 && busy_count > 0)
            idx = pick_busy_slot();
        else if (roll < 85)
            idx = INDEX_W'($urandom_range(0, SLOT_COUNT - 1));
        else
            idx = INDEX_W'($urandom_range(0, 255));
        case ($urandom_range(0, 2))
            0: want_gen = '0;
            1: want_gen = (idx < SLOT_COUNT) ? EXPECT_W'(slot_gen[idx[SLOT_W-1:0]])
                                             : $urandom;
            default: want_gen = $urandom;
        endcase
        send_word(op, idx, random_data(), want_gen);
    endtask

    task automatic test_fresh_table();
        write_notify(1'b0);
        send_word(OP_LOOKUP, 8'd0, '0, '0);
        send_word(OP_VALIDATE, 8'd63, '0, '0);
        send_word(OP_VALIDATE, 8'd63, '1, '1);
        send_word(OP_RELEASE, 8'd5, '0, '0);
        send_word(OP_SILENT_RELEASE, 8'd63, '0, '0);
        send_word(OP_LOOKUP, 8'd64, '0, '0);
        send_word(OP_VALIDATE, 8'd255, '1, '1);
        send_word(OP_RELEASE, 8'd128, '0, '0);
        send_word(OP_SPARE_FIRST, 8'd0, '0, '0);
        send_word(OP_SPARE_LAST, 8'd255, '1, '1);
    endtask

    task automatic test_acquire_and_release();
        send_word(OP_ACQUIRE, 8'd255, '1, '1);
        send_word(OP_ACQUIRE, 8'd0, '0, '0);
        send_word(OP_LOOKUP, 8'd0, '0, '0);
        send_word(OP_VALIDATE, 8'd0, '0, 32'd1);
        send_word(OP_VALIDATE, 8'd0, '0, 32'd2);
        send_word(OP_RELEASE, 8'd0, '0, '0);
        send_word(OP_SILENT_RELEASE, 8'd1, '0, '0);
    endtask

    task automatic test_evict_notify();
        logic [INDEX_W-1:0] first;
        settle();
        write_notify(1'b1);
        first = INDEX_W'(next_hint);
        send_word(OP_ACQUIRE, '0, 64'hA5A5_0F0F_5A5A_F0F0, '0);
        send_word(OP_ACQUIRE, '0, '0, '0);
        send_word(OP_RELEASE, first, '0, '0);
        send_word(OP_RELEASE, first + 1'b1, '0, '0);
        send_word(OP_ACQUIRE, '0, 64'h1, '0);
        send_word(OP_SILENT_RELEASE, first + 2'd2, '0, '0);
        settle();
        write_notify(1'b0);
    endtask

    task automatic test_fill_to_capacity();
        int k;
        sender_idle = 1'b0;
        sink_idle = 1'b1;
        while (busy_count < SLOT_COUNT)
            send_word(OP_ACQUIRE, INDEX_W'($urandom_range(0, 255)), random_data(), $urandom);
        send_word(OP_ACQUIRE, '0, random_data(), '0);
        send_word(OP_ACQUIRE, '1, random_data(), '1);
        sender_idle = 1'b1;
        for (k = 0; k < 10; k++)
            random_word(0);
    endtask

    task automatic test_random_traffic();
        int acquire_pct [4];
        int chunk;
        int k;
        acquire_pct = '{55, 25, 70, 40};
        for (chunk = 0; chunk < 4; chunk++)
        begin
            settle();
            write_notify(chunk % 2 == 0);
            sender_idle = (chunk == 0) || (chunk == 2);
            sink_idle = (chunk == 0) || (chunk == 3);
            for (k = 0; k < 80; k++)
                random_word(acquire_pct[chunk]);
        end
    endtask

    task automatic check_field(string field_name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (awaited_responses.size() == 0)
            begin
                $display("%0t: response word with none expected, expected nothing, actual %h",
                         $time, rsp.status);
                mismatch_count++;
            end
            else
            begin
                want = awaited_responses.pop_front();
                check_field("status", 64'(want.status), 64'(rsp.status));
                check_field("granted_slot", 64'(want.granted_slot), 64'(rsp.granted_slot));
                check_field("read_data", want.read_data, rsp.read_data);
                check_field("generation_out", 64'(want.generation_out),
                            64'(rsp.generation_out));
                check_field("is_occupied", 64'(want.is_occupied), 64'(rsp.is_occupied));
                check_field("is_valid", 64'(want.is_valid), 64'(rsp.is_valid));
                check_field("evict", 64'(want.evict), 64'(rsp.evict));
                check_field("active_slots", 64'(want.active_slots), 64'(rsp.active_slots));
            end
            results_checked++;
        end
    end

    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!(rsp.valid === 1'b1 && rsp.ready === 1'b1))
                @(posedge clk);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run exceeded %0d cycles with %0d responses outstanding",
                 $time, CYCLE_LIMIT, awaited_responses.size());
        $display("** generation_tagged_slot_allocator_top: FAILED **");
        $finish;
    end

    initial
    begin
        int k;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        req.valid = 1'b0;
        req.op = OP_ACQUIRE;
        req.slot_index = '0;
        req.store_data = '0;
        req.check_gen = '0;
        sender_idle = 1'b1;
        sink_idle = 1'b1;
        mismatch_count = 0;
        words_sent = 0;
        results_checked = 0;
        no_free_seen = 0;
        out_of_range_seen = 0;
        evictions_seen = 0;
        for (k = 0; k < SLOT_COUNT; k++)
        begin
            slot_busy[k] = 1'b0;
            slot_word[k] = '0;
            slot_gen[k] = '0;
        end
        next_hint = 0;
        busy_count = 0;
        notify_on = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fresh_table();
        test_acquire_and_release();
        test_evict_notify();
        test_fill_to_capacity();
        test_random_traffic();
        settle();

        $display("Sent %0d request words and checked %0d responses over both notify settings.",
                 words_sent, results_checked);
        $display("Saw %0d full-table acquires, %0d out-of-range ids and %0d evictions.",
                 no_free_seen, out_of_range_seen, evictions_seen);
        if (mismatch_count == 0 && awaited_responses.size() == 0)
            $display("** generation_tagged_slot_allocator_top: PASSED **");
        else
            $display("** generation_tagged_slot_allocator_top: FAILED **");
        $finish;
    end

endmodule

// ===== generation_tagged_slot_allocator_top.f =====
sv/gtsa_pkg.sv
sv/gtsa_if.sv
sv/gtsa_ram.sv
sv/gtsa_finder.sv
sv/generation_tagged_slot_allocator_top.sv
tb/generation_tagged_slot_allocator_top_tb.sv
